/* sv/skf_pkg.sv */
// shared types and constants for the sorted keyframe table
package skf_pkg;

  localparam int unsigned MAX_KEYS_DEF = 64;
  localparam int unsigned FRAME_W      = 32;
  localparam int unsigned HANDLE_W     = 16;
  localparam int unsigned DUR_W        = 34;
  localparam int unsigned OP_W         = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT    = 2'd0,
    OP_LOOKUP    = 2'd1,
    OP_SET_FIRST = 2'd2,
    OP_SET_LAST  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INS_SCAN,
    ST_INS_PUT,
    ST_LK_SCAN
  } state_e;

  typedef struct packed {
    logic signed [FRAME_W-1:0] frame;
    logic [HANDLE_W-1:0]       handle;
  } entry_t;

endpackage

/* sv/sorted_keyframe_table_top.sv */
// sorted keyframe table: ordered key storage with insert, bracket lookup and range
// timing: set commands, refused inserts and empty lookups give their result in the cycle
// after accept; a lookup scans the keys from index 0 up to the first key later than the
// query, or through all keys when none is later; an insert shifts the later keys up one
// at a time from the top; both scans are paced by the single read/write port pair of memory.
// one command at a time; the next may start in the cycle done_o is high.
// reset clears key count and range to zero; key memory is not cleared.
module sorted_keyframe_table_top #(
  parameter int unsigned MAX_KEYS = skf_pkg::MAX_KEYS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [skf_pkg::OP_W-1:0]             op_i,
  input  logic signed [skf_pkg::FRAME_W-1:0]   frame_i,
  input  logic [skf_pkg::HANDLE_W-1:0]         key_handle_i,
  output logic                                 done_o,
  output logic                                 table_empty_o,
  output logic                                 table_full_o,
  output logic [skf_pkg::HANDLE_W-1:0]         before_handle_o,
  output logic signed [skf_pkg::FRAME_W-1:0]   before_frame_o,
  output logic [skf_pkg::HANDLE_W-1:0]         after_handle_o,
  output logic signed [skf_pkg::FRAME_W-1:0]   after_frame_o,
  output logic signed [skf_pkg::FRAME_W-1:0]   range_first_o,
  output logic signed [skf_pkg::FRAME_W-1:0]   range_last_o,
  output logic signed [skf_pkg::DUR_W-1:0]     duration_o
);
  import skf_pkg::*;

  localparam int unsigned AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned CW = $clog2(MAX_KEYS + 1);

  state_e state_q, state_d;

  entry_t mem [MAX_KEYS];
  entry_t rdata_q;
  logic   mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t mem_wdata;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic signed [FRAME_W-1:0] frame_q, frame_d;
  logic [HANDLE_W-1:0] handle_q, handle_d;
  entry_t prev_q, prev_d;
  entry_t before_q, before_d, after_q, after_d;
  logic signed [FRAME_W-1:0] first_q, first_d, last_q, last_d;
  logic full_q, full_d;
  logic done_q, done_d;

  logic accept;
  logic later;
  logic is_full;
  logic [CW-1:0] idx_m1, idx_m2, idx_p1, count_m1;
  entry_t new_entry;

  assign accept    = start_i && (state_q == ST_IDLE);
  assign later     = rdata_q.frame > frame_q;
  assign is_full   = count_q >= CW'(MAX_KEYS);
  assign idx_m1    = idx_q - 1'b1;
  assign idx_m2    = idx_q - CW'(2);
  assign idx_p1    = idx_q + 1'b1;
  assign count_m1  = count_q - 1'b1;
  assign new_entry = '{frame: frame_q, handle: handle_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_e'(op_i))
            OP_INSERT: begin
              if (!is_full) begin
                state_d = (count_q == '0) ? ST_INS_PUT : ST_INS_SCAN;
              end
            end
            OP_LOOKUP: begin
              if (count_q != '0) begin
                state_d = ST_LK_SCAN;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_INS_SCAN: begin
        if (!later) begin
          state_d = ST_IDLE;
        end else if (idx_q == CW'(1)) begin
          state_d = ST_INS_PUT;
        end
      end
      ST_INS_PUT: state_d = ST_IDLE;
      ST_LK_SCAN: begin
        if (later || idx_q == count_m1) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q[AW-1:0];
    mem_wdata = new_entry;
    mem_raddr = idx_m2[AW-1:0];
    count_d   = count_q;
    idx_d     = idx_q;
    frame_d   = frame_q;
    handle_d  = handle_q;
    prev_d    = prev_q;
    before_d  = before_q;
    after_d   = after_q;
    first_d   = first_q;
    last_d    = last_q;
    full_d    = full_q;
    done_d    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          frame_d  = frame_i;
          handle_d = key_handle_i;
          before_d = '0;
          after_d  = '0;
          full_d   = 1'b0;
          case (op_e'(op_i))
            OP_INSERT: begin
              if (is_full) begin
                full_d = 1'b1;
                done_d = 1'b1;
              end else begin
                idx_d     = count_q;
                mem_raddr = count_m1[AW-1:0];
              end
            end
            OP_LOOKUP: begin
              idx_d     = '0;
              mem_raddr = '0;
              if (count_q == '0) begin
                done_d = 1'b1;
              end
            end
            OP_SET_FIRST: begin
              first_d = frame_i;
              done_d  = 1'b1;
            end
            OP_SET_LAST: begin
              last_d = frame_i;
              done_d = 1'b1;
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      ST_INS_SCAN: begin
        mem_we = 1'b1;
        if (later) begin
          mem_wdata = rdata_q;
          idx_d     = idx_m1;
        end else begin
          count_d = count_q + 1'b1;
          if (frame_q < first_q) first_d = frame_q;
          if (frame_q > last_q) last_d = frame_q;
          done_d = 1'b1;
        end
      end
      ST_INS_PUT: begin
        mem_we  = 1'b1;
        count_d = count_q + 1'b1;
        if (frame_q < first_q) first_d = frame_q;
        if (frame_q > last_q) last_d = frame_q;
        done_d = 1'b1;
      end
      ST_LK_SCAN: begin
        mem_raddr = idx_p1[AW-1:0];
        prev_d    = rdata_q;
        idx_d     = idx_p1;
        if (later) begin
          after_d  = rdata_q;
          before_d = (idx_q == '0) ? rdata_q : prev_q;
          done_d   = 1'b1;
        end else if (idx_q == count_m1) begin
          after_d  = rdata_q;
          before_d = rdata_q;
          done_d   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // key memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      first_q <= '0;
      last_q  <= '0;
      full_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      first_q <= first_d;
      last_q  <= last_d;
      full_q  <= full_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    frame_q  <= frame_d;
    handle_q <= handle_d;
    prev_q   <= prev_d;
    before_q <= before_d;
    after_q  <= after_d;
  end

  assign busy_o          = (state_q != ST_IDLE);
  assign done_o          = done_q;
  assign table_empty_o   = (count_q == '0);
  assign table_full_o    = full_q;
  assign before_handle_o = before_q.handle;
  assign before_frame_o  = before_q.frame;
  assign after_handle_o  = after_q.handle;
  assign after_frame_o   = after_q.frame;
  assign range_first_o   = first_q;
  assign range_last_o    = last_q;
  assign duration_o      = {{(DUR_W-FRAME_W){last_q[FRAME_W-1]}}, last_q}
                         - {{(DUR_W-FRAME_W){first_q[FRAME_W-1]}}, first_q}
                         + DUR_W'(1);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_KEYS))
    else $error("key count above capacity");

  a_full_only_at_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && full_q) |-> (count_q == CW'(MAX_KEYS)))
    else $error("insert refused below capacity");

  a_scan_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INS_SCAN) |-> (idx_q != '0 && idx_q <= count_q))
    else $error("insert shift index out of range");

  a_set_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_i == OP_SET_FIRST) |=> (done_o && range_first_o == $past(frame_i)))
    else $error("set first frame not applied");

endmodule

/* tb/sorted_keyframe_table_top_test.sv */
// self-checking testbench for the sorted keyframe table: directed and random command traffic vs a predictor
`timescale 1ns / 100ps

module sorted_keyframe_table_top_test;

  import skf_pkg::*;

  localparam int KEY_CAP = MAX_KEYS_DEF;

  typedef logic signed [FRAME_W-1:0] frame_t;
  typedef logic [HANDLE_W-1:0] handle_t;

  typedef struct packed {
    logic                      empty;
    logic                      full;
    logic [HANDLE_W-1:0]       before_handle;
    logic signed [FRAME_W-1:0] before_frame;
    logic [HANDLE_W-1:0]       after_handle;
    logic signed [FRAME_W-1:0] after_frame;
    logic signed [FRAME_W-1:0] range_first;
    logic signed [FRAME_W-1:0] range_last;
    logic signed [DUR_W-1:0]   duration;
  } bracket_reply_t;

  class keyframe_table_score;
    frame_t         shadow_frames[KEY_CAP];
    handle_t        shadow_handles[KEY_CAP];
    int             key_count;
    frame_t         first_frame;
    frame_t         last_frame;
    bracket_reply_t owed_replies[$];
    int             mismatch_count;

    function new();
      key_count      = 0;
      first_frame    = '0;
      last_frame     = '0;
      mismatch_count = 0;
    endfunction

    function void apply_command(op_e op, frame_t frame, handle_t handle);
      bracket_reply_t r;
      int             pos;
      int             idx;
      int             brk;
      int             prior;
      bit             later;
      longint         span;
      r = '0;
      case (op)
        OP_INSERT: begin
          if (key_count >= KEY_CAP) begin
            r.full = 1'b1;
          end else begin
            pos = 0;
            while (pos < key_count && shadow_frames[pos] <= frame) pos++;
            for (idx = key_count; idx > pos; idx--) begin
              shadow_frames[idx]  = shadow_frames[idx-1];
              shadow_handles[idx] = shadow_handles[idx-1];
            end
            shadow_frames[pos]  = frame;
            shadow_handles[pos] = handle;
            key_count++;
            if (frame < first_frame) first_frame = frame;
            if (frame > last_frame) last_frame = frame;
          end
        end
        OP_LOOKUP: begin
          if (key_count > 0) begin
            brk   = key_count - 1;
            later = 1'b0;
            for (idx = 0; idx < key_count; idx++) begin
              if (shadow_frames[idx] > frame) begin
                brk   = idx;
                later = 1'b1;
                break;
              end
            end
            if (!later) prior = key_count - 1;
            else if (brk == 0) prior = 0;
            else prior = brk - 1;
            r.before_handle = shadow_handles[prior];
            r.before_frame  = shadow_frames[prior];
            r.after_handle  = shadow_handles[brk];
            r.after_frame   = shadow_frames[brk];
          end
        end
        OP_SET_FIRST: first_frame = frame;
        default:      last_frame = frame;
      endcase
      span          = longint'(last_frame) - longint'(first_frame) + 1;
      r.empty       = (key_count == 0);
      r.range_first = first_frame;
      r.range_last  = last_frame;
      r.duration    = span[DUR_W-1:0];
      owed_replies  = {owed_replies, r};
    endfunction

    function void check_reply(bracket_reply_t got);
      bracket_reply_t want;
      if (owed_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected reply with no transaction pending");
        return;
      end
      want = owed_replies.pop_front();
      if (got.empty !== want.empty || got.full !== want.full ||
          got.before_handle !== want.before_handle || got.before_frame !== want.before_frame ||
          got.after_handle !== want.after_handle || got.after_frame !== want.after_frame ||
          got.range_first !== want.range_first || got.range_last !== want.range_last ||
          got.duration !== want.duration) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("mismatch exp: empty %0b full %0b bef %h/%0d aft %h/%0d rng %0d..%0d dur %0d",
                   want.empty, want.full, want.before_handle, want.before_frame,
                   want.after_handle, want.after_frame, want.range_first, want.range_last,
                   want.duration);
          $display("         got: empty %0b full %0b bef %h/%0d aft %h/%0d rng %0d..%0d dur %0d",
                   got.empty, got.full, got.before_handle, got.before_frame,
                   got.after_handle, got.after_frame, got.range_first, got.range_last,
                   got.duration);
        end
      end
    endfunction
  endclass

  logic                      clk_i        = 1'b0;
  logic                      rst_ni       = 1'b0;
  logic                      start_i      = 1'b0;
  logic [OP_W-1:0]           op_i         = OP_INSERT;
  logic signed [FRAME_W-1:0] frame_i      = '0;
  logic [HANDLE_W-1:0]       key_handle_i = '0;
  logic                      busy_o;
  logic                      done_o;
  logic                      table_empty_o;
  logic                      table_full_o;
  logic [HANDLE_W-1:0]       before_handle_o;
  logic signed [FRAME_W-1:0] before_frame_o;
  logic [HANDLE_W-1:0]       after_handle_o;
  logic signed [FRAME_W-1:0] after_frame_o;
  logic signed [FRAME_W-1:0] range_first_o;
  logic signed [FRAME_W-1:0] range_last_o;
  logic signed [DUR_W-1:0]   duration_o;

  keyframe_table_score board;
  int                  burst_left = 0;

  sorted_keyframe_table_top i_dut (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .op_i,
    .frame_i,
    .key_handle_i,
    .done_o,
    .table_empty_o,
    .table_full_o,
    .before_handle_o,
    .before_frame_o,
    .after_handle_o,
    .after_frame_o,
    .range_first_o,
    .range_last_o,
    .duration_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #6_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk_i) begin
    bracket_reply_t got;
    if (rst_ni && done_o) begin
      got.empty         = table_empty_o;
      got.full          = table_full_o;
      got.before_handle = before_handle_o;
      got.before_frame  = before_frame_o;
      got.after_handle  = after_handle_o;
      got.after_frame   = after_frame_o;
      got.range_first   = range_first_o;
      got.range_last    = range_last_o;
      got.duration      = duration_o;
      board.check_reply(got);
    end
  end

  // start stays high across back-to-back transactions inside a burst
  task automatic issue(op_e op, frame_t frame, handle_t handle);
    start_i      <= 1'b1;
    op_i         <= op;
    frame_i      <= frame;
    key_handle_i <= handle;
    do @(posedge clk_i); while (busy_o);
    board.apply_command(op, frame, handle);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  function automatic frame_t pick_frame(bit near_keys);
    int     sel;
    int     offs;
    frame_t f;
    sel = $urandom_range(0, 9);
    if (near_keys && board.key_count > 0 && sel < 4) begin
      offs = $urandom_range(0, 2);
      f    = board.shadow_frames[$urandom_range(0, board.key_count - 1)] + (offs - 1);
    end else if (sel == 4) begin
      f = $urandom;
    end else if (sel == 5) begin
      case ($urandom_range(0, 3))
        0:       f = 32'sh8000_0000;
        1:       f = 32'sh7fff_ffff;
        2:       f = -1;
        default: f = 0;
      endcase
    end else begin
      offs = $urandom_range(0, 60);
      f    = offs - 30;
    end
    return f;
  endfunction

  initial begin
    int   n;
    int   roll;
    op_e  op;
    board = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(OP_LOOKUP, 7, 16'hffff);
    issue(OP_SET_FIRST, 32'sh7fff_ffff, 16'h0000);
    issue(OP_SET_LAST, 32'sh8000_0000, 16'h0000);
    issue(OP_SET_FIRST, 32'sh8000_0000, 16'h0000);
    issue(OP_SET_LAST, 32'sh7fff_ffff, 16'h0000);
    issue(OP_SET_FIRST, 0, 16'h0000);
    issue(OP_SET_LAST, 0, 16'h0000);
    issue(OP_INSERT, 5, 16'hffff);
    issue(OP_INSERT, 5, 16'h0000);
    issue(OP_INSERT, -3, 16'h1234);
    issue(OP_LOOKUP, 5, 16'h0000);
    issue(OP_LOOKUP, -100, 16'h0000);
    issue(OP_LOOKUP, 0, 16'h0000);
    issue(OP_LOOKUP, -3, 16'h0000);
    issue(OP_INSERT, 32'sh8000_0000, 16'h0001);
    issue(OP_INSERT, 32'sh7fff_ffff, 16'h0002);
    issue(OP_INSERT, 5, 16'h5555);
    issue(OP_LOOKUP, 32'sh8000_0000, 16'h0000);
    issue(OP_LOOKUP, 32'sh7fff_ffff, 16'h0000);
    issue(OP_LOOKUP, 5, 16'h0000);
    issue(OP_LOOKUP, 4, 16'h0000);

    // inserts are a fifth of the commands, so the table fills a little over a third of the way through
    for (n = 0; n < 800; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 20) op = OP_INSERT;
      else if (roll < 70) op = OP_LOOKUP;
      else if (roll < 85) op = OP_SET_FIRST;
      else op = OP_SET_LAST;
      issue(op, pick_frame(op == OP_LOOKUP), handle_t'($urandom_range(0, 65535)));
    end
    start_i <= 1'b0;

    while (board.owed_replies.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (board.mismatch_count == 0 && board.owed_replies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/skf_pkg.sv
sv/sorted_keyframe_table_top.sv
tb/sorted_keyframe_table_top_test.sv
